### sv/nearest_neighbour_tour_core_macros.svh
// ----------------------------------------------------------------------------
// nearest neighbour tour core - assertion macros
// concurrent checks on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOUR_TOUR_CORE_MACROS_SVH
`define NEAREST_NEIGHBOUR_TOUR_CORE_MACROS_SVH

// antecedent and consequent in the same cycle
`define NNT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define NNT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/nnt_pkg.sv
// ----------------------------------------------------------------------------
// nnt_pkg
// shared types, widths and state codes of the nearest neighbour tour core
// ----------------------------------------------------------------------------
package nnt_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS     = 20;
  localparam int IDX_BITS       = 6;
  localparam int COUNT_BITS     = 7;
  localparam int DIFF_W         = COORD_BITS + 1;
  localparam int SUM_W          = 2 * DIFF_W;
  localparam int ROOT_W         = DIFF_W + 1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic                         last_point;
    logic [IDX_BITS-1:0]          start_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] point_index;
    logic                last_of_tour;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [IDX_BITS-1:0]   start;
  } build_cmd_t;

  typedef struct packed {
    logic done;
  } tour_status_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_GETSTART,
    BK_EMIT,
    BK_SCAN,
    BK_WAIT,
    BK_MUL,
    BK_ADD,
    BK_SQRT,
    BK_CMP
  } back_state_t;

endpackage

### sv/nnt_ram.sv
// ----------------------------------------------------------------------------
// nnt_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module nnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/nnt_fifo.sv
// ----------------------------------------------------------------------------
// nnt_fifo
// small register queue, used for build commands and for tour results
// ----------------------------------------------------------------------------
module nnt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : PW'(wp_r + 1'b1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : PW'(rp_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= wdata;
    end
  end

endmodule

### sv/nnt_front.sv
// ----------------------------------------------------------------------------
// nnt_front
// takes points, stores them in load order and issues one build command per set
// ----------------------------------------------------------------------------
module nnt_front #(
  parameter int MAX_POINTS = nnt_pkg::MAX_POINTS_DEF,
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  nnt_pkg::in_item_t         in_data,
  output logic                      wr_en,
  output logic [IDX_W-1:0]          wr_addr,
  output logic [2*nnt_pkg::COORD_BITS-1:0] wr_data,
  output logic                      cmd_push,
  output nnt_pkg::build_cmd_t       cmd_data,
  input  nnt_pkg::tour_status_t     status
);
  import nnt_pkg::*;

  logic [CNT_W-1:0]      cnt_r, cnt_nxt, cnt_after;
  logic                  busy_r, busy_nxt;
  logic                  acc, room;
  logic [COUNT_BITS-1:0] count_w, start_w;

  // the store is locked from the last point until the tour is fully handed on
  assign in_full = busy_r;
  assign acc     = in_push && !busy_r;
  assign room    = (cnt_r < CNT_W'(MAX_POINTS));

  assign wr_en   = acc && room;
  assign wr_addr = cnt_r[IDX_W-1:0];
  assign wr_data = {in_data.coord_x, in_data.coord_y};

  assign cnt_after = room ? CNT_W'(cnt_r + 1'b1) : cnt_r;
  assign count_w   = COUNT_BITS'(cnt_after);
  assign start_w   = COUNT_BITS'(in_data.start_index);

  // start index saturated to the last held point
  always_comb begin
    cmd_data.count = count_w;
    cmd_data.start = (start_w >= count_w) ? IDX_BITS'(count_w - 1'b1)
                                          : in_data.start_index;
  end

  assign cmd_push = acc && in_data.last_point;

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc) begin
      cnt_nxt = in_data.last_point ? '0 : cnt_after;
    end
    busy_nxt = busy_r;
    if (cmd_push) begin
      busy_nxt = 1'b1;
    end else if (status.done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

### sv/nnt_back.sv
// ----------------------------------------------------------------------------
// nnt_back
// greedy tour builder: scans the store, one distance and square root at a time
// ----------------------------------------------------------------------------
module nnt_back #(
  parameter int MAX_POINTS = nnt_pkg::MAX_POINTS_DEF,
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_valid,
  input  nnt_pkg::build_cmd_t       cmd_data,
  output logic                      cmd_pop,
  output logic                      rd_en,
  output logic [IDX_W-1:0]          rd_addr,
  input  logic [2*nnt_pkg::COORD_BITS-1:0] rd_data,
  output logic                      out_push,
  output nnt_pkg::out_item_t        out_data,
  input  logic                      out_full,
  output nnt_pkg::tour_status_t     status
);
  import nnt_pkg::*;

  `include "nearest_neighbour_tour_core_macros.svh"

  back_state_t state_r, state_nxt;

  logic [CNT_W-1:0]             count_r, i_r, emitted_r;
  logic [MAX_POINTS-1:0]        visited_r;
  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r, best_x_r, best_y_r;
  logic signed [COORD_BITS-1:0] cand_x_r, cand_y_r, rd_x, rd_y;
  logic [IDX_W-1:0]             best_idx_r;
  logic [ROOT_W-1:0]            best_d_r, cand_d;
  logic                         found_r, scan_end, seen, better;
  logic [DIFF_W-1:0]            ax_r, ay_r;
  logic signed [DIFF_W-1:0]     dx, dy;
  logic [SUM_W-1:0]             sqx_r, sqy_r, px, py;
  logic [SUM_W-1:0]             rem_r, res_r, bit_r, trial;
  out_item_t                    item_r;

  assign rd_x     = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign rd_y     = rd_data[COORD_BITS-1:0];
  assign scan_end = (i_r == count_r);
  assign seen     = visited_r[i_r[IDX_W-1:0]];
  assign dx       = DIFF_W'(rd_x) - DIFF_W'(cur_x_r);
  assign dy       = DIFF_W'(rd_y) - DIFF_W'(cur_y_r);
  assign px       = ax_r * ax_r;
  assign py       = ay_r * ay_r;
  assign trial    = res_r + bit_r;
  // round half up: remainder above the root means sqrt >= root + 0.5
  assign cand_d   = ROOT_W'(res_r) + ROOT_W'(rem_r > res_r);
  assign better   = !found_r || (cand_d < best_d_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:     if (cmd_valid) state_nxt = BK_GETSTART;
      BK_GETSTART: state_nxt = BK_EMIT;
      BK_EMIT: begin
        if (!out_full) begin
          state_nxt = item_r.last_of_tour ? BK_IDLE : BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_end) begin
          state_nxt = BK_EMIT;
        end else if (!seen) begin
          state_nxt = BK_WAIT;
        end
      end
      BK_WAIT:     state_nxt = BK_MUL;
      BK_MUL:      state_nxt = BK_ADD;
      BK_ADD:      state_nxt = BK_SQRT;
      BK_SQRT:     if (bit_r == SUM_W'(1)) state_nxt = BK_CMP;
      BK_CMP:      state_nxt = BK_SCAN;
      default:     state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = i_r[IDX_W-1:0];
    out_push    = 1'b0;
    status.done = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        cmd_pop = cmd_valid;
        rd_en   = cmd_valid;
        rd_addr = cmd_data.start[IDX_W-1:0];
      end
      BK_EMIT: begin
        out_push    = !out_full;
        status.done = !out_full && item_r.last_of_tour;
      end
      BK_SCAN: rd_en = !scan_end && !seen;
      default: ;
    endcase
  end

  assign out_data = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      visited_r <= '0;
      found_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        BK_IDLE: begin
          if (cmd_valid) begin
            visited_r <= '0;
            visited_r[cmd_data.start[IDX_W-1:0]] <= 1'b1;
          end
        end
        BK_EMIT: if (!out_full) found_r <= 1'b0;
        BK_SCAN: if (scan_end) visited_r[best_idx_r] <= 1'b1;
        BK_CMP:  found_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        count_r             <= cmd_data.count[CNT_W-1:0];
        emitted_r           <= '0;
        item_r.point_index  <= cmd_data.start;
        item_r.last_of_tour <= (cmd_data.count == COUNT_BITS'(1));
      end
      BK_GETSTART: begin
        cur_x_r <= rd_x;
        cur_y_r <= rd_y;
      end
      BK_EMIT: begin
        if (!out_full) begin
          emitted_r <= CNT_W'(emitted_r + 1'b1);
          i_r       <= '0;
        end
      end
      BK_SCAN: begin
        if (scan_end) begin
          cur_x_r             <= best_x_r;
          cur_y_r             <= best_y_r;
          item_r.point_index  <= IDX_BITS'(best_idx_r);
          item_r.last_of_tour <= (CNT_W'(emitted_r + 1'b1) == count_r);
        end else if (seen) begin
          i_r <= CNT_W'(i_r + 1'b1);
        end
      end
      BK_WAIT: begin
        cand_x_r <= rd_x;
        cand_y_r <= rd_y;
        ax_r     <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        ay_r     <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
      end
      BK_MUL: begin
        sqx_r <= px;
        sqy_r <= py;
      end
      BK_ADD: begin
        rem_r <= sqx_r + sqy_r;
        res_r <= '0;
        bit_r <= SUM_W'(1) << (SUM_W - 2);
      end
      BK_SQRT: begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      BK_CMP: begin
        if (better) begin
          best_d_r   <= cand_d;
          best_idx_r <= i_r[IDX_W-1:0];
          best_x_r   <= cand_x_r;
          best_y_r   <= cand_y_r;
        end
        i_r <= CNT_W'(i_r + 1'b1);
      end
      default: ;
    endcase
  end

  `NNT_ASSERT_SAME(a_sqrt_bit_onehot, state_r == BK_SQRT, $onehot(bit_r), "sqrt bit lost")
  `NNT_ASSERT_SAME(a_scan_found, state_r == BK_SCAN && scan_end, found_r, "scan ended empty")
  `NNT_ASSERT_SAME(a_emit_bound, state_r != BK_IDLE, emitted_r <= count_r, "tour overrun")
  `NNT_ASSERT_NEXT(a_done_idle, status.done, state_r == BK_IDLE, "done not idle")

endmodule

### sv/nearest_neighbour_tour_core.sv
// ----------------------------------------------------------------------------
// nearest_neighbour_tour_core
// loads a point set and emits a greedy nearest neighbour tour over it
// ----------------------------------------------------------------------------
// channel  ports                        payload
// input    in_push / in_full            in_data  : coord_x, coord_y, last_point,
//                                                  start_index
// result   out_pop / out_empty          out_data : point_index, last_of_tour
//
// a point is taken whenever in_full is low; the set is locked while its tour is built
// each tour step scans all held points; an unvisited one passes through a store
// read, absolute difference, multiply, add, an iterative square root and a
// compare, a visited one is skipped; each step then closes the scan and emits
// its point, and the serial square root unit sets the build time
// rst_n is synchronous; the point store needs no clearing pass
// a full result queue stalls the builder only; a build stalls the input side
// ----------------------------------------------------------------------------
module nearest_neighbour_tour_core #(
  parameter int MAX_POINTS = nnt_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  nnt_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output nnt_pkg::out_item_t out_data
);
  import nnt_pkg::*;

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CMD_W = $bits(build_cmd_t);
  localparam int RES_W = $bits(out_item_t);

  // store write side (front) and read side (back)
  logic                    wr_en, rd_en;
  logic [IDX_W-1:0]        wr_addr, rd_addr;
  logic [2*COORD_BITS-1:0] wr_data, rd_data;

  // build command queue between front and back
  build_cmd_t   cmd_in, cmd_out;
  logic         cmd_push, cmd_pop, cmd_full, cmd_empty;
  tour_status_t status;

  // result queue: builder pushes, result channel transfers
  out_item_t res_in;
  logic      res_push, res_full;

  nnt_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in),
    .status   (status)
  );

  // coordinate pairs, x in the upper half
  nnt_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(MAX_POINTS)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // front holds off new points until done, so the queue never overfills
  nnt_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  nnt_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_push  (res_push),
    .out_data  (res_in),
    .out_full  (res_full),
    .status    (status)
  );

  // output skid queue, head is shown on out_data while not empty
  nnt_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

  `include "nearest_neighbour_tour_core_macros.svh"

  `NNT_ASSERT_SAME(a_cmd_no_overflow, cmd_push, !cmd_full, "build command lost")
  `NNT_ASSERT_SAME(a_store_locked, rd_en && wr_en, 1'b0, "store written during build")
  `NNT_ASSERT_NEXT(a_push_locks, cmd_push, in_full, "input open after last point")

endmodule

### tb/sv/nearest_neighbour_tour_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbour_tour_core_tb
// feeds point sets into the tour core and checks each emitted tour index
// against a greedy nearest neighbour tour worked out here in integers
// ----------------------------------------------------------------------------
module nearest_neighbour_tour_core_tb;
  import nnt_pkg::*;

  localparam int NPTS = MAX_POINTS_DEF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_data = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_data;

  nearest_neighbour_tour_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: our own copy of the point set
  logic signed [COORD_BITS-1:0] px [NPTS];
  logic signed [COORD_BITS-1:0] py [NPTS];
  logic                         seen [NPTS];
  int unsigned                  held = 0;

  out_item_t tour_due[$];
  int        n_err = 0;
  int        n_items = 0;
  int        n_tours = 0;
  int        n_results = 0;
  bit        feed_done = 0;

  // rounded euclidean distance, exact in integers
  function automatic longint unsigned round_dist(int a, int b);
    longint signed     dx, dy;
    longint unsigned   s, r, bitv;
    dx = longint'(px[a]) - longint'(px[b]);
    dy = longint'(py[a]) - longint'(py[b]);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    s = dx * dx + dy * dy;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    begin
      longint unsigned n;
      n = s;
      while (bitv != 0) begin
        if (n >= r + bitv) begin
          n -= r + bitv;
          r = (r >> 1) + bitv;
        end else begin
          r >>= 1;
        end
        bitv >>= 2;
      end
    end
    if (s - r * r > r) r++;
    return r;
  endfunction

  // store the point; on the final one work out the whole greedy tour
  function automatic void predict_tour(in_item_t it);
    int unsigned     start, cur, best;
    bit              found;
    longint unsigned best_d, d;
    out_item_t       o;
    if (held < NPTS) begin
      px[held] = it.coord_x;
      py[held] = it.coord_y;
      held++;
    end
    if (!it.last_point) return;
    start = 32'(it.start_index);
    if (start >= held) start = held - 1;
    foreach (seen[i]) seen[i] = 1'b0;
    seen[start] = 1'b1;
    cur = start;
    o.point_index = start[IDX_BITS-1:0];
    o.last_of_tour = (held == 1);
    tour_due.insert(tour_due.size(), o);
    for (int k = 1; k < held; k++) begin
      found = 0;
      best = 0;
      best_d = 0;
      for (int i = 0; i < held; i++) begin
        if (!seen[i]) begin
          d = round_dist(cur, i);
          if (!found || d < best_d) begin
            found = 1;
            best_d = d;
            best = i;
          end
        end
      end
      seen[best] = 1'b1;
      cur = best;
      o.point_index = best[IDX_BITS-1:0];
      o.last_of_tour = (k == held - 1);
      tour_due.insert(tour_due.size(), o);
    end
    held = 0;
    n_tours++;
  endfunction

  // mostly short gaps, now and then a long one, sometimes none at all
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // send one point; returns after its transfer
  task automatic send_point(in_item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_tour(it);
    n_items++;
  endtask

  function automatic in_item_t mk_point(int x, int y, bit fin, int st);
    in_item_t it;
    it.coord_x = COORD_BITS'(x);
    it.coord_y = COORD_BITS'(y);
    it.last_point = fin;
    it.start_index = IDX_BITS'(st);
    return it;
  endfunction

  // directed rows: typed-in tour where it is obvious, else left to the predictor
  typedef struct {
    in_item_t  pt;
    bit        typed;
    out_item_t want;
  } row_t;
  row_t rows[$];

  function automatic void add_row(in_item_t p, bit typed = 0, int idx = 0, bit lst = 0);
    row_t r;
    r.pt = p;
    r.typed = typed;
    r.want.point_index = IDX_BITS'(idx);
    r.want.last_of_tour = lst;
    rows.insert(rows.size(), r);
  endfunction

  // random coordinate: full range, or a tight cluster to force ties
  function automatic int rnd_coord(bit tight);
    if (tight) return $urandom_range(6) - 3;
    return int'($urandom_range(20'hFFFFF)) - (1 << 19) * 0 - ((1 << 20) * 0);
  endfunction

  function automatic in_item_t rnd_point(bit fin, int st, bit tight);
    in_item_t it;
    it.coord_x = tight ? COORD_BITS'(rnd_coord(1)) : COORD_BITS'($urandom());
    it.coord_y = tight ? COORD_BITS'(rnd_coord(1)) : COORD_BITS'($urandom());
    it.last_point = fin;
    it.start_index = IDX_BITS'(st);
    return it;
  endfunction

  // stimulus
  initial begin
    int sz, st;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single point, start far out of range: saturates to index zero
    add_row(mk_point(0, 0, 1, 63), 1, 0, 1);
    // extremes of both coordinates, start on the last point
    add_row(mk_point(-524288, -524288, 0, 0));
    add_row(mk_point(524287, 524287, 0, 0));
    add_row(mk_point(-524288, 524287, 0, 0));
    add_row(mk_point(524287, -524288, 1, 3));
    // a tie: both neighbours at distance 1, lowest index wins
    add_row(mk_point(0, 0, 0, 0));
    add_row(mk_point(1, 0, 0, 0));
    add_row(mk_point(-1, 0, 1, 0));
    // duplicate points and a start of 2 out of range for 2 points
    add_row(mk_point(5, 5, 0, 0));
    add_row(mk_point(5, 5, 1, 2));
    // non-integer distances exercise the rounding
    add_row(mk_point(0, 0, 0, 42));
    add_row(mk_point(1, 1, 0, 0));
    add_row(mk_point(2, 1, 1, 21));

    foreach (rows[i]) begin
      send_point(rows[i].pt);
      // single-point row: typed result must agree with the predictor
      if (rows[i].typed && tour_due.size() > 0 && tour_due[$] != rows[i].want) begin
        $error("typed tour mismatch: expected %p actual prediction %p",
               rows[i].want, tour_due[$]);
        n_err++;
      end
    end

    // one full store plus an extra point that is dropped, then build
    for (int i = 0; i < NPTS; i++) send_point(rnd_point(0, 0, i[0]));
    send_point(rnd_point(1, $urandom_range(63), 0));

    // random sets, mostly small so builds stay quick
    while (n_items < 120) begin
      sz = ($urandom_range(9) == 0) ? $urandom_range(24, 10) : $urandom_range(6, 1);
      st = $urandom_range(63);
      for (int i = 0; i < sz; i++)
        send_point(rnd_point(i == sz - 1, st, $urandom_range(2) == 0));
    end
    in_push <= 1'b0;
    feed_done = 1;
  end

  // result side: random stalls, check against the oldest expectation
  initial begin
    out_item_t e;
    int g;
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_pop <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      if (rst_n && !out_empty) begin
        if (tour_due.size() == 0) begin
          $error("unexpected transfer: point_index %0d", out_data.point_index);
          n_err++;
        end else begin
          e = tour_due[0];
          tour_due.delete(0);
          n_results++;
          if (out_data.point_index !== e.point_index) begin
            $error("point_index: expected %0d actual %0d", e.point_index,
                   out_data.point_index);
            n_err++;
          end
          if (out_data.last_of_tour !== e.last_of_tour) begin
            $error("last_of_tour: expected %0d actual %0d", e.last_of_tour,
                   out_data.last_of_tour);
            n_err++;
          end
        end
      end
    end
  end

  // end of run: drain, then a short settle
  initial begin
    wait (feed_done);
    while (tour_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d points in %0d tours, %0d tour indices checked",
             n_items, n_tours, n_results);
    if (n_err == 0 && tour_due.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
